@@ sv/tsd_pkg.sv @@
// Shared types and constants of the task slot dispatcher.
// Depends on nothing; used by every module of the block.
package tsd_pkg;

	// Default sizing of the dispatch table and the worker pool
	localparam int TSD_SLOTS   = 16;
	localparam int TSD_WORKERS = 8;

	// Request queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TOTAL_TASKS = 2'd0;
	localparam logic [1:0] CFG_FAILED_NODE = 2'd1;
	localparam logic [1:0] CFG_REPAIR_MODE = 2'd2;

	// Reset value of the total task register
	localparam logic [15:0] TOTAL_TASKS_RST = 16'd16;

	// Saturation level of a worker's completion counter
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Command codes of a request
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DONE  = 1'b1;

	// Request kinds after decode
	typedef enum logic {
		KIND_START,
		KIND_DONE
	} req_kind_t;

	// Slot status codes
	typedef enum logic [1:0] {
		SS_WAIT = 2'd0,
		SS_RUN  = 2'd1,
		SS_DONE = 2'd2
	} slot_status_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BS_IDLE,
		BS_FIND,
		BS_UPDATE,
		BS_SEARCH,
		BS_EMIT
	} back_state_t;

	// One classified request as it waits in the queue
	typedef struct packed {
		req_kind_t   kind;
		logic [2:0]  worker;
		logic [15:0] task_id;
	} req_t;

	// One finished result handed to the output stage
	typedef struct packed {
		logic        dispatch_valid;
		logic [15:0] dispatch_task;
		logic [2:0]  dispatch_worker;
		logic [3:0]  dispatch_slot;
		logic        all_done;
		logic        unknown_task;
		logic [15:0] worker_count;
	} result_t;

endpackage

@@ sv/tsd_front.sv @@
// Front end of the task slot dispatcher: accepts requests, decodes the command
// and holds them in a short queue for the back end. Depends on tsd_pkg.
module tsd_front import tsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [2:0]  worker,
	input  logic [15:0] finished_task,
	output logic        q_valid,
	output req_t        q_req,
	input  logic        q_pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	req_t            queue_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            push;
	req_t            req_in;

	// Decode the command into a request kind
	always_comb begin
		req_in.worker  = worker;
		req_in.task_id = finished_task;
		case (command)
			CMD_START: req_in.kind = KIND_START;
			CMD_DONE:  req_in.kind = KIND_DONE;
			default:   req_in.kind = KIND_START;
		endcase
	end

	assign item_stall = (fill_q == CW'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (fill_q != '0);
	assign q_req      = queue_q[rd_ptr_q];

	// Store an accepted request
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= req_in;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ sv/tsd_back.sv @@
// Back end of the task slot dispatcher: slot lookup, refill, completion count
// and circular dispatch search, one slot per cycle. Depends on tsd_pkg.
module tsd_back import tsd_pkg::*; #(
	parameter int SLOTS   = TSD_SLOTS,
	parameter int WORKERS = TSD_WORKERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] total_tasks,
	input  logic        q_valid,
	input  req_t        q_req,
	output logic        q_pop,
	output logic        res_valid,
	output result_t     res,
	input  logic        res_ready
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = SW + 1;
	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam logic [6:0] WORKERS_V = 7'(WORKERS);

	back_state_t    state_q, state_d;

	// Request in progress
	logic [2:0]     worker_q;
	logic [15:0]    task_q;

	// Slot table: task numbers in memory, status and written marks in flops
	logic [15:0]    task_mem [SLOTS];
	logic [SLOTS-1:0] written_q;
	slot_status_t   status_q [SLOTS];
	logic [16:0]    next_task_q;
	logic [CW-1:0]  done_cnt_q;

	// Table read pipeline
	logic           rd_vld_s1;
	logic [SW-1:0]  rd_idx_s1;
	logic           rd_wr_s1;
	logic [15:0]    rd_data_s1;
	logic           rd_en;
	logic [SW-1:0]  rd_addr;
	logic [15:0]    rd_task;

	// Lookup and search
	logic [CW-1:0]  idx_q;
	logic [SW-1:0]  pos_q;
	logic [SW-1:0]  s_q;
	logic [SW-1:0]  s_next;
	logic [SW-1:0]  pos_next;
	logic [CW-1:0]  steps_q;
	logic [SW-1:0]  pick_q;
	logic           pick_vld_q;
	logic           unknown_q;
	logic           counted_q;

	// Worker completion counters
	logic [15:0]    cnt_mem [WORKERS];
	logic [WORKERS-1:0] cnt_written_q;
	logic [15:0]    cnt_rd_s1;
	logic           cnt_wr_s1;
	logic [15:0]    cnt_val;
	logic [15:0]    cnt_inc;
	logic [WW-1:0]  wk_idx_in;
	logic [WW-1:0]  wk_idx;
	logic           wk_ok_in;
	logic           wk_ok;

	// Sequencer strobes
	logic           issue_find;
	logic           find_hit;
	logic           find_miss;
	logic           do_update;
	logic           refill;
	logic           search_hit;

	// Derive lookup data, counter values and wrap-around indexes
	always_comb begin
		rd_task   = rd_wr_s1 ? rd_data_s1 : 16'(rd_idx_s1);
		cnt_val   = cnt_wr_s1 ? cnt_rd_s1 : 16'd0;
		cnt_inc   = (cnt_val != COUNT_MAX) ? cnt_val + 16'd1 : cnt_val;
		wk_idx_in = WW'(q_req.worker);
		wk_idx    = WW'(worker_q);
		wk_ok_in  = ({4'b0, q_req.worker} < WORKERS_V);
		wk_ok     = ({4'b0, worker_q} < WORKERS_V);
		refill    = (next_task_q < {1'b0, total_tasks});
		s_next    = (s_q == SW'(SLOTS - 1)) ? '0 : s_q + 1'b1;
		pos_next  = (pos_q == SW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;
		rd_addr   = (state_q == BS_FIND) ? idx_q[SW-1:0] : s_q;
	end

	// Next state and sequencer strobes
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		issue_find = 1'b0;
		find_hit   = 1'b0;
		find_miss  = 1'b0;
		do_update  = 1'b0;
		search_hit = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_req.kind == KIND_START) ? BS_SEARCH : BS_FIND;
				end
			end
			BS_FIND: begin
				issue_find = (idx_q < CW'(SLOTS));
				if (rd_vld_s1 && rd_task == task_q) begin
					find_hit = 1'b1;
					state_d  = BS_UPDATE;
				end else if (rd_vld_s1 && rd_idx_s1 == SW'(SLOTS - 1)) begin
					find_miss = 1'b1;
					state_d   = BS_EMIT;
				end
			end
			BS_UPDATE: begin
				do_update = 1'b1;
				state_d   = BS_SEARCH;
			end
			BS_SEARCH: begin
				if (status_q[s_q] == SS_WAIT) begin
					search_hit = 1'b1;
					state_d    = BS_EMIT;
				end else if (steps_q == CW'(1)) begin
					state_d    = BS_EMIT;
				end
			end
			BS_EMIT: begin
				if (res_ready) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	assign rd_en = issue_find || search_hit;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot task memory: refill write and one registered read
	always_ff @(posedge clk) begin
		if (do_update && refill) begin
			task_mem[pos_q] <= next_task_q[15:0];
		end
		if (rd_en) begin
			rd_data_s1 <= task_mem[rd_addr];
			rd_wr_s1   <= written_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Worker counter memory: read on pop, write on completion
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (wk_ok_in) begin
				cnt_rd_s1 <= cnt_mem[wk_idx_in];
				cnt_wr_s1 <= cnt_written_q[wk_idx_in];
			end else begin
				cnt_rd_s1 <= 16'd0;
				cnt_wr_s1 <= 1'b0;
			end
		end
		if (do_update && wk_ok) begin
			cnt_mem[wk_idx] <= cnt_inc;
		end
	end

	// Latch the request and the search bookkeeping
	always_ff @(posedge clk) begin
		if (q_pop) begin
			worker_q <= q_req.worker;
			task_q   <= q_req.task_id;
			s_q      <= '0;
			steps_q  <= CW'(SLOTS);
		end else if (do_update) begin
			s_q     <= pos_next;
			steps_q <= CW'(SLOTS);
		end else if (state_q == BS_SEARCH && !search_hit) begin
			s_q     <= s_next;
			steps_q <= steps_q - 1'b1;
		end
		if (find_hit) begin
			pos_q <= rd_idx_s1;
		end
		if (search_hit) begin
			pick_q <= s_q;
		end
	end

	// Control flags, table status and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1     <= 1'b0;
			idx_q         <= '0;
			pick_vld_q    <= 1'b0;
			unknown_q     <= 1'b0;
			counted_q     <= 1'b0;
			written_q     <= '0;
			cnt_written_q <= '0;
			next_task_q   <= 17'(SLOTS);
			done_cnt_q    <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= SS_WAIT;
			end
		end else begin
			rd_vld_s1 <= issue_find;
			if (q_pop) begin
				idx_q      <= '0;
				pick_vld_q <= 1'b0;
				unknown_q  <= 1'b0;
				counted_q  <= 1'b0;
			end else if (issue_find) begin
				idx_q <= idx_q + 1'b1;
			end
			if (find_miss) begin
				unknown_q <= 1'b1;
			end
			// Refill the found slot or retire it
			if (do_update) begin
				counted_q <= 1'b1;
				if (refill) begin
					status_q[pos_q]  <= SS_WAIT;
					written_q[pos_q] <= 1'b1;
					next_task_q      <= next_task_q + 17'd1;
					if (status_q[pos_q] == SS_DONE) begin
						done_cnt_q <= done_cnt_q - 1'b1;
					end
				end else begin
					status_q[pos_q] <= SS_DONE;
					if (status_q[pos_q] != SS_DONE) begin
						done_cnt_q <= done_cnt_q + 1'b1;
					end
				end
				if (wk_ok) begin
					cnt_written_q[wk_idx] <= 1'b1;
				end
			end
			// Hand the picked slot to the worker
			if (search_hit) begin
				status_q[s_q] <= SS_RUN;
				pick_vld_q    <= 1'b1;
			end
		end
	end

	// Assemble the result
	always_comb begin
		res_valid           = (state_q == BS_EMIT);
		res.dispatch_valid  = pick_vld_q;
		res.dispatch_task   = pick_vld_q ? rd_task : 16'd0;
		res.dispatch_worker = worker_q;
		res.dispatch_slot   = pick_vld_q ? 4'(pick_q) : 4'd0;
		res.all_done        = (done_cnt_q == CW'(SLOTS));
		res.unknown_task    = unknown_q;
		if (!wk_ok) begin
			res.worker_count = 16'd0;
		end else if (counted_q) begin
			res.worker_count = cnt_inc;
		end else begin
			res.worker_count = cnt_val;
		end
	end

endmodule

@@ sv/task_slot_dispatcher_unit.sv @@
// Top level of the task slot dispatcher: configuration registers, front end,
// back end and output register. Depends on tsd_pkg, tsd_front and tsd_back.
//
// A start request runs the dispatch search alone; a completion report first
// runs the slot lookup, which walks the task memory through its single read
// port, one slot a cycle, and, when the task is found, the dispatch search,
// which walks the status table one slot a cycle from the slot after the found
// one (a start request searches from slot 0). A two-entry request queue lets
// new requests be accepted while one is being worked, and the output register
// holds a result while the next one is built.
// Reset needs no clearing pass; configuration writes are taken at once.
module task_slot_dispatcher_unit import tsd_pkg::*; #(
	parameter int SLOTS   = TSD_SLOTS,
	parameter int WORKERS = TSD_WORKERS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Requests
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [2:0]  worker,
	input  logic [15:0] finished_task,
	// Results
	output logic        result_valid,
	input  logic        result_stall,
	output logic        dispatch_valid,
	output logic [15:0] dispatch_task,
	output logic [2:0]  dispatch_worker,
	output logic [3:0]  dispatch_slot,
	output logic [7:0]  node_echo,
	output logic [7:0]  mode_echo,
	output logic        all_done,
	output logic        unknown_task,
	output logic [15:0] worker_count
);

	logic [15:0] total_tasks_q;
	logic [7:0]  failed_node_q;
	logic [7:0]  repair_mode_q;

	logic        q_valid;
	req_t        q_req;
	logic        q_pop;
	logic        res_valid;
	result_t     res;
	logic        res_ready;

	result_t     out_q;
	logic [7:0]  node_q;
	logic [7:0]  mode_q;
	logic        out_vld_q;

	// Take configuration writes at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_tasks_q <= TOTAL_TASKS_RST;
			failed_node_q <= '0;
			repair_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOTAL_TASKS: total_tasks_q <= cfg_data;
				CFG_FAILED_NODE: failed_node_q <= cfg_data[7:0];
				CFG_REPAIR_MODE: repair_mode_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.worker        (worker),
		.finished_task (finished_task),
		.q_valid       (q_valid),
		.q_req         (q_req),
		.q_pop         (q_pop)
	);

	tsd_back #(
		.SLOTS   (SLOTS),
		.WORKERS (WORKERS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.total_tasks (total_tasks_q),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// Load the output register when it is empty or being drained
	assign res_ready = !out_vld_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q  <= res;
			node_q <= res.dispatch_valid ? failed_node_q : 8'd0;
			mode_q <= res.dispatch_valid ? repair_mode_q : 8'd0;
		end
	end

	assign result_valid    = out_vld_q;
	assign dispatch_valid  = out_q.dispatch_valid;
	assign dispatch_task   = out_q.dispatch_task;
	assign dispatch_worker = out_q.dispatch_worker;
	assign dispatch_slot   = out_q.dispatch_slot;
	assign node_echo       = node_q;
	assign mode_echo       = mode_q;
	assign all_done        = out_q.all_done;
	assign unknown_task    = out_q.unknown_task;
	assign worker_count    = out_q.worker_count;

endmodule
